// File: rtl/core/nds_pkg.sv
`timescale 1ns / 1ps

package nds_pkg;

  localparam int unsigned DataW      = 16;
  localparam int unsigned ProdW      = 2 * DataW;
  localparam int unsigned AccW       = 40;
  localparam int unsigned FracBits   = 12;
  localparam int unsigned SumW       = AccW - FracBits;
  localparam int unsigned MaxTerms   = 128;
  localparam int unsigned CntW       = $clog2(MaxTerms + 1);
  localparam int unsigned TableBits  = 8;
  localparam int unsigned TableDepth = 1 << TableBits;
  localparam int unsigned TableStep  = 1 << (DataW - TableBits);
  localparam int unsigned ExpFrac    = 38;
  localparam int unsigned ExpTerms   = 80;
  localparam int unsigned OutMax     = (1 << DataW) - 1;

  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic        [DataW-1:0] rom_t [TableDepth];

  // Long division, used only while building the activation table.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(mag/4096) in unsigned Q38, Taylor series with truncated terms.
  // floor(floor(a/4096)/i) equals floor(a/(4096*i)).
  function automatic logic [63:0] exp_q38(input logic [63:0] mag);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'(1) << ExpFrac;
    sum  = 64'(1) << ExpFrac;
    for (int i = 1; i < ExpTerms; i++) begin
      if (term != '0) begin
        term = div_u64((term * mag) >> FracBits, 64'(i));
        sum  = sum + term;
      end
    end
    return sum;
  endfunction

  // Entry k: round(65535 / (1 + exp(c/4096))), c at the center of bin k.
  function automatic rom_t build_rom();
    rom_t        rom;
    longint      c;
    logic [63:0] mag;
    logic [63:0] den;
    logic [63:0] y;
    for (int k = 0; k < TableDepth; k++) begin
      c   = longint'(k) * longint'(TableStep) - longint'(1 << (DataW - 1))
            + longint'(TableStep / 2);
      mag = (c < 0) ? 64'(-c) : 64'(c);
      den = (64'(1) << ExpFrac) + exp_q38(mag);
      y   = div_u64(64'(2) * 64'(OutMax) * (64'(1) << ExpFrac) + den, 64'(2) * den);
      rom[k] = (c >= 0) ? y[DataW-1:0] : DataW'(64'(OutMax) - y);
    end
    return rom;
  endfunction

  localparam rom_t SigRom = build_rom();

  // Signed add that clamps at the accumulator limits.
  function automatic acc_t sat_add(input acc_t a, input acc_t b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    return s[AccW-1:0];
  endfunction

endpackage

// File: rtl/core/neuron_dot_product_sigmoid.sv
`timescale 1ns / 1ps
// A last-term transaction moves through the product, accumulate and table
// registers before its result shows on neuron_out_o; stalls can hold it.
// Throughput: one transaction per cycle unless a last term waits on the index register;
//   the multiply and the 40-bit saturating accumulate each sit between their own registers.
// Reset (rst_ni low, asynchronous): accumulator and term count cleared, pipe empty.
module neuron_dot_product_sigmoid (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [nds_pkg::DataW-1:0]     weight_i,
  input  logic signed [nds_pkg::DataW-1:0]     act_in_i,
  input  logic signed [nds_pkg::DataW-1:0]     bias_i,
  input  logic                                 last_term_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [nds_pkg::DataW-1:0]     neuron_out_o
);

  // ---- Stage 1: product register ----
  logic                                p_valid_q;
  logic                                last_q;
  logic signed [nds_pkg::ProdW-1:0]    prod_q;
  logic signed [nds_pkg::ProdW-1:0]    prod_d;
  logic signed [nds_pkg::DataW-1:0]    bias_q;

  // ---- Stage 2: accumulator and table index ----
  nds_pkg::acc_t                       acc_q;
  logic        [nds_pkg::CntW-1:0]     cnt_q;
  logic                                res_valid_q;
  logic        [nds_pkg::TableBits-1:0] idx_q;

  // ---- Stage 3: output register ----
  logic                                out_valid_q;
  logic        [nds_pkg::DataW-1:0]    out_q;

  // Handshake / flow control
  logic out_adv;   // output register can take a new result
  logic s2_free;   // index register is empty or drains this cycle
  logic s1_adv;    // stage-1 transaction moves through the accumulator
  logic load_out;  // index register moves into the output register
  logic in_fire;

  assign out_adv  = !out_valid_q || out_ready_i;
  assign load_out = res_valid_q && out_adv;
  assign s2_free  = !res_valid_q || out_adv;
  // Non-last terms never need the index register, so they flow past a held result.
  assign s1_adv   = p_valid_q && (!last_q || s2_free);
  assign in_ready_o = !p_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Q4.12 x Q4.12 gives an exact Q8.24 product.
  assign prod_d = nds_pkg::ProdW'(weight_i) * nds_pkg::ProdW'(act_in_i);

  // Accumulate datapath
  logic                                term_ok;
  nds_pkg::acc_t                       sum1;
  nds_pkg::acc_t                       bias_ext;
  nds_pkg::acc_t                       sum2;
  logic signed [nds_pkg::SumW-1:0]     shifted;
  logic        [nds_pkg::DataW-1:0]    sat16;
  logic        [nds_pkg::DataW-1:0]    biased;
  logic        [nds_pkg::TableBits-1:0] idx_d;

  always_comb begin
    // Products past the term limit are dropped.
    term_ok  = cnt_q < nds_pkg::CntW'(nds_pkg::MaxTerms);
    sum1     = term_ok ? nds_pkg::sat_add(acc_q, nds_pkg::AccW'(prod_q)) : acc_q;
    bias_ext = nds_pkg::AccW'(bias_q) <<< nds_pkg::FracBits;
    sum2     = nds_pkg::sat_add(sum1, bias_ext);
    // Arithmetic shift floors toward minus infinity.
    shifted  = sum2[nds_pkg::AccW-1:nds_pkg::FracBits];
    if (!shifted[nds_pkg::SumW-1] && (|shifted[nds_pkg::SumW-2:nds_pkg::DataW-1])) begin
      sat16 = {1'b0, {(nds_pkg::DataW-1){1'b1}}};
    end else if (shifted[nds_pkg::SumW-1] && !(&shifted[nds_pkg::SumW-2:nds_pkg::DataW-1])) begin
      sat16 = {1'b1, {(nds_pkg::DataW-1){1'b0}}};
    end else begin
      sat16 = shifted[nds_pkg::DataW-1:0];
    end
    // Adding 32768 to a 16-bit signed value just flips its sign bit.
    biased = {~sat16[nds_pkg::DataW-1], sat16[nds_pkg::DataW-2:0]};
    idx_d  = biased[nds_pkg::DataW-1:nds_pkg::DataW-nds_pkg::TableBits];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      last_q      <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        p_valid_q <= in_valid_i;
        last_q    <= last_term_i;
      end

      if (s1_adv) begin
        if (last_q) begin
          acc_q <= '0;
          cnt_q <= '0;
        end else begin
          acc_q <= sum1;
          if (term_ok) begin
            cnt_q <= cnt_q + nds_pkg::CntW'(1);
          end
        end
      end

      res_valid_q <= (res_valid_q && !load_out) || (s1_adv && last_q);
      out_valid_q <= load_out || (out_valid_q && !out_ready_i);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prod_q <= prod_d;
      bias_q <= bias_i;
    end
    if (s1_adv && last_q) begin
      idx_q <= idx_d;
    end
    if (load_out) begin
      out_q <= nds_pkg::SigRom[idx_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign neuron_out_o = out_q;

endmodule

// File: tb/sv/neuron_dot_product_sigmoid_tb.sv
`timescale 1ns / 1ps

// Checks the streamed dot product plus logistic table lookup.
// The driver streams weight/activation pairs from a queue and predicts each
// neuron on its last-term transaction. The monitor compares every result
// against the oldest prediction.
module neuron_dot_product_sigmoid_tb;

  localparam int unsigned DW          = nds_pkg::DataW;
  localparam int unsigned FracW       = 12;
  localparam int unsigned LutBits     = 8;
  localparam int unsigned LutDepth    = 1 << LutBits;
  localparam longint      LutStep     = longint'(1) << (DW - LutBits);
  localparam int unsigned ExpQ        = 38;
  localparam int unsigned SeriesLen   = 80;
  localparam int unsigned TermCap     = 128;
  localparam int unsigned AccBits     = 40;
  localparam longint      AccHi       = (longint'(1) <<< (AccBits - 1)) - 1;
  localparam longint      AccLo       = -AccHi - 1;
  localparam int unsigned RandPerPhase = 184;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned QuietLimit  = 2000;

  typedef logic signed [DW-1:0] q4_12_t;
  typedef logic        [DW-1:0] q0_16_t;

  typedef struct {
    q4_12_t weight;
    q4_12_t act_in;
    q4_12_t bias;
    logic   last_term;
  } term_t;

  // DUT ports; the inputs are known from time zero
  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  q4_12_t weight_i    = '0;
  q4_12_t act_in_i    = '0;
  q4_12_t bias_i      = '0;
  logic   last_term_i = 1'b0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  q0_16_t neuron_out_o;

  // Pending input transactions and predicted activations
  term_t  term_fifo[$];
  q0_16_t expected_outs[$];

  // Predictor state: Q8.24 running sum and terms taken for this neuron
  q0_16_t      logistic_rom [LutDepth];
  longint      dot_acc;
  int unsigned terms_in_neuron;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_cnt        = 0;
  int unsigned quiet_cycles   = 0;

  neuron_dot_product_sigmoid dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .weight_i     (weight_i),
    .act_in_i     (act_in_i),
    .bias_i       (bias_i),
    .last_term_i  (last_term_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .neuron_out_o (neuron_out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // One table entry: round(65535 / (1 + exp(c/4096))) with c at the bin
  // center. exp() is a truncated Taylor series in unsigned Q38, all integer.
  function automatic q0_16_t logistic_entry(input int unsigned k);
    longint      ctr;
    logic [63:0] mag;
    logic [63:0] term;
    logic [63:0] esum;
    logic [63:0] den;
    logic [63:0] y;
    ctr  = longint'(k) * LutStep - longint'(32768) + LutStep / 2;
    mag  = (ctr < 0) ? 64'(-ctr) : 64'(ctr);
    term = 64'd1 << ExpQ;
    esum = term;
    for (int i = 1; i < SeriesLen && term != 0; i++) begin
      term = (term * mag) / (64'd4096 * 64'(i));
      esum = esum + term;
    end
    den = (64'd1 << ExpQ) + esum;
    y   = (64'd2 * 64'd65535 * (64'd1 << ExpQ) + den) / (64'd2 * den);
    return (ctr >= 0) ? y[DW-1:0] : DW'(64'd65535 - y);
  endfunction

  function automatic longint clamp_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > AccHi) return AccHi;
    if (s < AccLo) return AccLo;
    return s;
  endfunction

  // Fold one accepted term into the running sum; on the last term, finish
  // the neuron and queue the activation it must produce.
  function automatic void accumulate_term(input term_t t);
    longint sum_q;
    int     idx;
    // products past the term cap are dropped, the last term still closes
    if (terms_in_neuron < TermCap) begin
      dot_acc = clamp_add(dot_acc, longint'(t.weight) * longint'(t.act_in));
      terms_in_neuron++;
    end
    if (t.last_term) begin
      dot_acc = clamp_add(dot_acc, longint'(t.bias) * 4096);
      sum_q   = dot_acc >>> FracW;        // floor toward minus infinity
      if (sum_q > 32767)  sum_q = 32767;
      if (sum_q < -32768) sum_q = -32768;
      idx = int'((sum_q + 32768) >> (DW - LutBits));
      expected_outs.push_back(logistic_rom[idx]);
      dot_acc         = 0;
      terms_in_neuron = 0;
    end
  endfunction

  // Mostly values near +-1.0 so sums land inside the table's live range;
  // some full-width values and the corner codes.
  function automatic q4_12_t pick_fixed();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) return q4_12_t'($urandom);
    if (roll < 35) begin
      case ($urandom_range(3))
        0:       return q4_12_t'(16'h8000);
        1:       return q4_12_t'(16'h7fff);
        2:       return q4_12_t'(16'hffff);
        default: return '0;
      endcase
    end
    return q4_12_t'($urandom_range(8192) - 4096);
  endfunction

  function automatic void push_term(input q4_12_t w, input q4_12_t a, input q4_12_t b,
                                    input logic lst);
    term_fifo.push_back(term_t'{w, a, b, lst});
  endfunction

  function automatic void queue_neuron(input int unsigned n_terms);
    for (int unsigned i = 0; i < n_terms; i++) begin
      push_term(pick_fixed(), pick_fixed(), pick_fixed(), i == n_terms - 1);
    end
  endfunction

  // Driver: predicts on each accepted transaction, then either holds the
  // current one or presents the next (or idles) once the slot is free.
  always @(posedge clk_i) begin : drive_terms
    term_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        accumulate_term(term_t'{weight_i, act_in_i, bias_i, last_term_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (term_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = term_fifo.pop_front();
          in_valid_i  <= 1'b1;
          weight_i    <= nxt.weight;
          act_in_i    <= nxt.act_in;
          bias_i      <= nxt.bias;
          last_term_i <= nxt.last_term;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, in-order compare of each result
  always @(posedge clk_i) begin : check_outs
    q0_16_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outs.size() == 0) begin
          $error("neuron_out: unexpected result 0x%04h", neuron_out_o);
          err_cnt++;
        end else begin
          want = expected_outs.pop_front();
          if (neuron_out_o !== want) begin
            $error("neuron_out mismatch: expected 0x%04h, actual 0x%04h", want, neuron_out_o);
            err_cnt++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("neuron_dot_product_sigmoid_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned fill_goal;
    int unsigned roll;
    for (int unsigned k = 0; k < LutDepth; k++) begin
      logistic_rom[k] = logistic_entry(k);
    end
    dot_acc         = 0;
    terms_in_neuron = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      // idling profile per phase: none, sender gaps, receiver stalls, both
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase

      if (p == 0) begin
        // zero sum lands on the center bin
        push_term(16'sd0, 16'sd0, 16'sd0, 1'b1);
        // largest positive product plus max bias: shifted sum clips high
        push_term(16'sh8000, 16'sh8000, 16'sh7fff, 1'b1);
        // largest negative product plus min bias: clips low
        push_term(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
        push_term(16'sh7fff, 16'sh7fff, 16'sd0, 1'b1);
        // bias alone, both extremes and -1
        push_term(16'sd0, 16'sd0, 16'sh7fff, 1'b1);
        push_term(16'sd0, 16'sd0, 16'sh8000, 1'b1);
        push_term(16'sd0, 16'sd0, 16'shffff, 1'b1);
        // floor: just below one LSB stays 0, tiny negative goes to -1
        push_term(16'sd1, 16'sd4095, 16'sd0, 1'b1);
        push_term(16'shffff, 16'sd1, 16'sd0, 1'b1);
        // multi-term neuron, bias on non-last terms must be ignored
        push_term(16'sd4096, 16'sd4096, 16'sh8000, 1'b0);
        push_term(-16'sd4096, 16'sd2048, 16'sh7fff, 1'b0);
        push_term(16'sd12345, 16'shffff, -16'sd4096, 1'b1);
        push_term(16'sd100, 16'sd200, 16'sh8000, 1'b0);
        push_term(16'sd300, -16'sd400, 16'sh7fff, 1'b1);
      end

      fill_goal = term_fifo.size() + RandPerPhase;
      // one neuron around the term cap per phase
      queue_neuron(TermCap - 1 + 4 * p);
      while (term_fifo.size() < fill_goal) begin
        roll = $urandom_range(99);
        if (roll < 90)      queue_neuron($urandom_range(8, 1));
        else if (roll < 97) queue_neuron($urandom_range(40, 9));
        else                queue_neuron($urandom_range(TermCap + 12, TermCap - 8));
      end
      while (term_fifo.size() != 0) @(posedge clk_i);
    end

    while (in_valid_i || expected_outs.size() != 0) @(posedge clk_i);
    // catch any stray result after the last expected one
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("neuron_dot_product_sigmoid_tb OK");
    end else begin
      $display("neuron_dot_product_sigmoid_tb NOT OK");
    end
    $finish;
  end

endmodule
